/* src/pkdlp_pkg.sv */
// Package with the types and constants shared by the key debounce and long-press unit.
`timescale 1ns / 1ps
`default_nettype none
package pkdlp_pkg;

  localparam int unsigned KEY_W = 6;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned DEB_W = 8;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MASK = 2'd2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd5;
  localparam logic [ELAPSED_W-1:0] LONG_TICKS_RST = 16'd1000;
  localparam logic [KEY_W-1:0] LONG_MASK_RST = 6'd32;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [DEB_W-1:0]     debounce_ticks;
    logic [ELAPSED_W-1:0] long_press_ticks;
    logic [KEY_W-1:0]     long_press_mask;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] key_code;
    logic              long_press;
  } res_t;

endpackage
`default_nettype wire

/* src/priority_key_debounce_long_press_unit.sv */
// Top level of the priority key debounce and long-press unit.
`timescale 1ns / 1ps
`default_nettype none
// Each input beat is one tick carrying the pressed levels of the keys; the lowest-index pressed
// key is tracked, checked again after the debounce time and reported once on release, with a
// long flag when its mask bit is set and the elapsed ticks exceeded the threshold. One beat is
// taken every cycle unless the input stage stalls: a beat is registered, then handled by the state
// machine, and a result is written to the output register when its releasing beat is handled. The
// input stage only stalls when a beat is held in the input register while a
// result beat is still waiting at the output. Registers are written through the cfg_ port,
// which is always ready; indexes beyond the list are ignored.
module priority_key_debounce_long_press_unit #(
  parameter int unsigned NUM_KEYS = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [pkdlp_pkg::KEY_W-1:0]       in_pressed_keys,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [pkdlp_pkg::CODE_W-1:0]           out_key_code,
  output logic                                   out_long_press,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pkdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pkdlp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pkdlp_pkg::cfg_t                   cfg_r;
  logic                              stg_vld_r;
  logic [pkdlp_pkg::KEY_W-1:0]       stg_keys_r;
  logic                              out_vld_r;
  logic [pkdlp_pkg::CODE_W-1:0]      out_code_r;
  logic                              out_long_r;
  logic                              advance;
  pkdlp_pkg::res_t                   res;

  assign cfg_ready = 1'b1;
  assign advance = !stg_vld_r || !out_vld_r || out_ready;
  assign in_ready = advance;
  assign out_valid = out_vld_r;
  assign out_key_code = out_code_r;
  assign out_long_press = out_long_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= pkdlp_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ticks <= pkdlp_pkg::LONG_TICKS_RST;
      cfg_r.long_press_mask  <= pkdlp_pkg::LONG_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pkdlp_pkg::CFG_DEBOUNCE:   cfg_r.debounce_ticks <= cfg_wdata[pkdlp_pkg::DEB_W-1:0];
        pkdlp_pkg::CFG_LONG_TICKS: cfg_r.long_press_ticks <= cfg_wdata;
        pkdlp_pkg::CFG_LONG_MASK:  cfg_r.long_press_mask <= cfg_wdata[pkdlp_pkg::KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (advance) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_keys_r <= in_pressed_keys;
    end
  end

  pkdlp_fsm #(
    .NUM_KEYS (NUM_KEYS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (stg_vld_r && advance),
    .levels (stg_keys_r),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_code_r <= res.key_code;
      out_long_r <= res.long_press;
    end
  end

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_code <= 3'd5))
    else $error("Result beat carries a key code beyond the last key.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stg_vld_r && out_vld_r && !out_ready))
    else $error("Input held off without a blocked result beat.");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |=> out_valid)
    else $error("A released key did not reach the output register.");

  a_result_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> (stg_vld_r && advance))
    else $error("Result produced without a registered input beat.");

endmodule
`default_nettype wire

/* src/pkdlp_fsm.sv */
// Tracking state machine: key scan, debounce check, hold timing and release result.
`timescale 1ns / 1ps
`default_nettype none
module pkdlp_fsm #(
  parameter int unsigned NUM_KEYS = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [pkdlp_pkg::KEY_W-1:0]  levels,
  input  wire pkdlp_pkg::cfg_t              cfg,
  output pkdlp_pkg::res_t                   res
);

  localparam int unsigned SCAN_KEYS =
    (NUM_KEYS < pkdlp_pkg::KEY_W) ? NUM_KEYS : pkdlp_pkg::KEY_W;
  localparam logic [pkdlp_pkg::KEY_W-1:0] SCAN_MASK =
    pkdlp_pkg::KEY_W'((1 << SCAN_KEYS) - 1);

  pkdlp_pkg::phase_t                 phase_r, phase_nxt;
  logic [pkdlp_pkg::CODE_W-1:0]      key_r, key_nxt;
  logic [pkdlp_pkg::ELAPSED_W-1:0]   elapsed_r, elapsed_nxt, elapsed_inc;
  logic [pkdlp_pkg::KEY_W-1:0]       scan;
  logic [7:0]                        scan_ext;
  logic [7:0]                        mask_ext;
  logic                              tracked_down;
  logic                              any_down;
  logic [pkdlp_pkg::CODE_W-1:0]      first_key;

  assign scan = levels & SCAN_MASK;
  assign scan_ext = {2'b00, scan};
  assign mask_ext = {2'b00, cfg.long_press_mask};
  assign tracked_down = scan_ext[key_r];
  assign any_down = |scan;
  assign elapsed_inc = (elapsed_r == pkdlp_pkg::ELAPSED_MAX) ? elapsed_r
                                                              : elapsed_r + 1'b1;

  always_comb begin
    first_key = '0;
    for (int k = pkdlp_pkg::KEY_W - 1; k >= 0; k--) begin
      if (scan[k]) begin
        first_key = pkdlp_pkg::CODE_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= pkdlp_pkg::PH_IDLE;
      key_r     <= '0;
      elapsed_r <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      key_r     <= key_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    key_nxt        = key_r;
    elapsed_nxt    = elapsed_r;
    res.vld        = 1'b0;
    res.key_code   = key_r;
    res.long_press = mask_ext[key_r] && (elapsed_inc > cfg.long_press_ticks);
    case (phase_r)
      pkdlp_pkg::PH_DEBOUNCE: begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc >= {8'd0, cfg.debounce_ticks}) begin
          phase_nxt = tracked_down ? pkdlp_pkg::PH_HOLD : pkdlp_pkg::PH_IDLE;
        end
      end
      pkdlp_pkg::PH_HOLD: begin
        elapsed_nxt = elapsed_inc;
        if (!tracked_down) begin
          res.vld   = step;
          phase_nxt = pkdlp_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = pkdlp_pkg::PH_IDLE;
        if (any_down) begin
          key_nxt     = first_key;
          elapsed_nxt = '0;
          phase_nxt   = pkdlp_pkg::PH_DEBOUNCE;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* test/priority_key_debounce_long_press_unit_tb.sv */
// Testbench for the key debounce and long-press unit, scoring each key release against a predictor.
`timescale 1ns / 1ps
module priority_key_debounce_long_press_unit_tb;

  localparam logic [pkdlp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE = 4;
  localparam int HOLD_OFF_CYCLES = 200;

  typedef enum int {CLEAN, CHATTER, DROPOUT} press_style_t;

  typedef struct packed {
    logic [pkdlp_pkg::CODE_W-1:0] key_code;
    logic                         long_press;
  } release_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [pkdlp_pkg::KEY_W-1:0] in_pressed_keys = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [pkdlp_pkg::CODE_W-1:0] out_key_code;
  logic out_long_press;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pkdlp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pkdlp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [pkdlp_pkg::KEY_W-1:0] ticks[$];
  release_t releases[$];

  pkdlp_pkg::cfg_t m_cfg;
  pkdlp_pkg::phase_t m_phase;
  logic [pkdlp_pkg::CODE_W-1:0] m_key;
  logic [pkdlp_pkg::ELAPSED_W-1:0] m_elapsed;

  int send_idle_pct = 26;
  int recv_idle_pct = 64;
  bit hold_off_req = 1'b0;
  int hold_cnt = 0;
  int plan_deb = 5;
  int plan_lp = 1000;
  int errors = 0;
  int beats_taken = 0;
  int releases_checked = 0;
  int long_seen = 0;

  priority_key_debounce_long_press_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_pressed_keys(in_pressed_keys),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_key_code(out_key_code),
    .out_long_press(out_long_press),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("== FAIL ==");
    $finish;
  end

  task automatic track_keys(input logic [pkdlp_pkg::KEY_W-1:0] lv);
    release_t r;
    case (m_phase)
      pkdlp_pkg::PH_DEBOUNCE: begin
        if (m_elapsed != pkdlp_pkg::ELAPSED_MAX) m_elapsed++;
        if (m_elapsed >= pkdlp_pkg::ELAPSED_W'(m_cfg.debounce_ticks)) begin
          m_phase = lv[m_key] ? pkdlp_pkg::PH_HOLD : pkdlp_pkg::PH_IDLE;
        end
      end
      pkdlp_pkg::PH_HOLD: begin
        if (m_elapsed != pkdlp_pkg::ELAPSED_MAX) m_elapsed++;
        if (!lv[m_key]) begin
          r.key_code = m_key;
          r.long_press = m_cfg.long_press_mask[m_key] && (m_elapsed > m_cfg.long_press_ticks);
          releases.push_back(r);
          m_phase = pkdlp_pkg::PH_IDLE;
        end
      end
      default: begin
        m_phase = pkdlp_pkg::PH_IDLE;
        for (int k = pkdlp_pkg::KEY_W - 1; k >= 0; k--) begin
          if (lv[k]) begin
            m_key = pkdlp_pkg::CODE_W'(k);
            m_elapsed = '0;
            m_phase = pkdlp_pkg::PH_DEBOUNCE;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_pressed_keys <= ticks.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_req && hold_cnt < HOLD_OFF_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : scoreboard
    release_t want;
    if (!rst_n) begin
      m_cfg = '{pkdlp_pkg::DEBOUNCE_RST, pkdlp_pkg::LONG_TICKS_RST, pkdlp_pkg::LONG_MASK_RST};
      m_phase = pkdlp_pkg::PH_IDLE;
      m_key = '0;
      m_elapsed = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pkdlp_pkg::CFG_DEBOUNCE:
            m_cfg.debounce_ticks = cfg_wdata[pkdlp_pkg::DEB_W-1:0];
          pkdlp_pkg::CFG_LONG_TICKS:
            m_cfg.long_press_ticks = cfg_wdata[pkdlp_pkg::ELAPSED_W-1:0];
          pkdlp_pkg::CFG_LONG_MASK:
            m_cfg.long_press_mask = cfg_wdata[pkdlp_pkg::KEY_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        track_keys(in_pressed_keys);
        beats_taken++;
      end
      if (out_valid && out_ready) begin
        if (releases.size() == 0) begin
          $error("result beat with no release pending: key_code %0d, long_press %0d",
                 out_key_code, out_long_press);
          errors++;
        end else begin
          want = releases.pop_front();
          releases_checked++;
          if (want.long_press) long_seen++;
          if (out_key_code !== want.key_code) begin
            $error("key_code: expected %0d, got %0d", want.key_code, out_key_code);
            errors++;
          end
          if (out_long_press !== want.long_press) begin
            $error("long_press: expected %0d, got %0d", want.long_press, out_long_press);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [pkdlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pkdlp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pkdlp_pkg::CFG_DEBOUNCE) plan_deb = int'(val[pkdlp_pkg::DEB_W-1:0]);
    if (idx == pkdlp_pkg::CFG_LONG_TICKS) plan_lp = int'(val);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (ticks.size() != 0 || in_valid || releases.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // A crowded press holds every higher key as well, on the release beat too.
  task automatic push_press(input int key, input int hold, input press_style_t style,
                            input bit crowd);
    logic [pkdlp_pkg::KEY_W-1:0] lv;
    if (style == DROPOUT) hold = (plan_deb > 0) ? plan_deb - 1 : 0;
    lv = crowd ? '1 : pkdlp_pkg::KEY_W'($urandom);
    lv[key] = 1'b1;
    for (int b = 0; b < key; b++) lv[b] = 1'b0;
    ticks.push_back(lv);
    for (int i = 1; i <= hold; i++) begin
      lv = crowd ? '1 : pkdlp_pkg::KEY_W'($urandom);
      if (style != CLEAN && i < plan_deb) lv[key] = 1'($urandom_range(1));
      else lv[key] = 1'b1;
      ticks.push_back(lv);
    end
    lv = crowd ? '1 : pkdlp_pkg::KEY_W'($urandom);
    lv[key] = 1'b0;
    ticks.push_back(lv);
    repeat ($urandom_range(2)) ticks.push_back('0);
    if ($urandom_range(7) == 0) ticks.push_back(pkdlp_pkg::KEY_W'($urandom));
  endtask

  task automatic push_random_press();
    int pick;
    press_style_t style;
    pick = $urandom_range(9);
    style = (pick < 7) ? CLEAN : (pick < 9) ? CHATTER : DROPOUT;
    push_press($urandom_range(pkdlp_pkg::KEY_W - 1), $urandom_range(2 * plan_lp + 3), style,
               $urandom_range(5) == 0);
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct, input bit squeeze);
    int n;
    wait_idle();
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    write_reg(pkdlp_pkg::CFG_DEBOUNCE, pkdlp_pkg::CFG_DATA_W'($urandom_range(1, 8)));
    write_reg(pkdlp_pkg::CFG_LONG_TICKS, pkdlp_pkg::CFG_DATA_W'($urandom_range(1, 12)));
    write_reg(pkdlp_pkg::CFG_LONG_MASK, pkdlp_pkg::CFG_DATA_W'($urandom_range(63)));
    if (squeeze) hold_off_req <= 1'b1;
    n = 0;
    while (ticks.size() < 80 || n < 7) begin
      push_random_press();
      n++;
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of the registers, empty beats and a crowd of keys.
    ticks.push_back('0);
    ticks.push_back('0);
    push_press(5, 8, CLEAN, 1'b0);
    push_press(0, 6, CLEAN, 1'b1);
    wait_idle();

    // Zero debounce through a masked write, the shortest threshold and the full mask.
    write_reg(CFG_UNUSED, 16'hFFFF);
    write_reg(pkdlp_pkg::CFG_DEBOUNCE, 16'hFF00);
    write_reg(pkdlp_pkg::CFG_LONG_TICKS, 16'd1);
    write_reg(pkdlp_pkg::CFG_LONG_MASK, 16'hFFFF);
    for (int k = 0; k < pkdlp_pkg::KEY_W; k++) push_press(k, k, CLEAN, k == 0);
    push_press(2, 3, DROPOUT, 1'b0);
    push_press(4, 4, CHATTER, 1'b1);
    wait_idle();

    // Long debounce with long presses masked off.
    write_reg(pkdlp_pkg::CFG_DEBOUNCE, 16'd30);
    write_reg(pkdlp_pkg::CFG_LONG_TICKS, 16'd40);
    write_reg(pkdlp_pkg::CFG_LONG_MASK, 16'd0);
    push_press(3, 45, CLEAN, 1'b0);
    push_press(4, 35, CHATTER, 1'b0);
    push_press(5, 0, DROPOUT, 1'b0);

    run_random_phase(26, 64, 1'b1);
    run_random_phase(64, 26, 1'b0);
    run_random_phase(0, 0, 1'b0);

    // The top threshold can never be exceeded.
    wait_idle();
    write_reg(pkdlp_pkg::CFG_DEBOUNCE, 16'd1);
    write_reg(pkdlp_pkg::CFG_LONG_TICKS, 16'hFFFF);
    write_reg(pkdlp_pkg::CFG_LONG_MASK, 16'd63);
    push_press(1, 10, CLEAN, 1'b0);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Drove %0d tick beats and checked %0d key releases, %0d of them long presses.",
             beats_taken, releases_checked, long_seen);
    $display("Debounce ran from 0 to 30 ticks, thresholds from 1 to 65535, with a stalled output.");
    if (errors == 0 && releases.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pkdlp_pkg.sv
src/pkdlp_fsm.sv
src/priority_key_debounce_long_press_unit.sv
test/priority_key_debounce_long_press_unit_tb.sv
